FILE: src/eppa_pkg.sv
// Shared types, constants and the microprogram for the projective point unit.
// No dependencies; used by eppa_alu, eppa_ram users and the top level.
package eppa_pkg;

	localparam int RF_DEPTH = 32;
	localparam int RF_AW    = 5;
	localparam int PC_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_CURVE_A = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'd1;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_DBL = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT, ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		FU_ADD, FU_SUB, FU_MUL, FU_MOD
	} fu_op_t;

	typedef struct packed {
		logic   start;
		fu_op_t op;
	} fu_req_t;

	typedef enum logic [4:0] {
		U_ADD, U_SUB, U_MUL, U_MOD, U_MOV, U_EQ, U_EQCLR, U_LDI, U_OUT,
		U_BR, U_JMP, U_CALL, U_RET, U_SHR, U_LDREM, U_ERR, U_DONE
	} uop_t;

	typedef enum logic [2:0] {
		C_OP_ADD, C_OP_DBL, C_OP_MUL, C_SC_ZERO, C_REM_ODD, C_REM_EVEN, C_REM_ZERO, C_EQ
	} cond_t;

	typedef enum logic [2:0] {
		SRC_FX, SRC_FY, SRC_FZ, SRC_SX, SRC_SY, SRC_SZ, SRC_CA, SRC_THREE
	} src_t;

	typedef struct packed {
		uop_t             kind;
		logic [RF_AW-1:0] dst;
		logic [RF_AW-1:0] sa;
		logic [RF_AW-1:0] sb;
		cond_t            cond;
		src_t             src;
		logic [PC_W-1:0]  tgt;
	} instr_t;

	// register file map: running sum, running double, result, scratch
	localparam logic [RF_AW-1:0] R_A0 = 5'd0, R_A1 = 5'd1, R_A2 = 5'd2;
	localparam logic [RF_AW-1:0] R_D0 = 5'd3, R_D1 = 5'd4, R_D2 = 5'd5;
	localparam logic [RF_AW-1:0] R_O0 = 5'd6, R_O1 = 5'd7, R_O2 = 5'd8;
	localparam logic [RF_AW-1:0] T0 = 5'd9, T1 = 5'd10, T2 = 5'd11, T3 = 5'd12;
	localparam logic [RF_AW-1:0] T4 = 5'd13, T5 = 5'd14, T6 = 5'd15, T7 = 5'd16;
	localparam logic [RF_AW-1:0] T8 = 5'd17, T9 = 5'd18, T10 = 5'd19, T11 = 5'd20;
	localparam logic [RF_AW-1:0] T12 = 5'd21, T13 = 5'd22, T14 = 5'd23, T15 = 5'd24;
	localparam logic [RF_AW-1:0] T16 = 5'd25, T17 = 5'd26;

	// program labels
	localparam logic [PC_W-1:0] L_ERR  = 7'd3;
	localparam logic [PC_W-1:0] L_ADD  = 7'd4;
	localparam logic [PC_W-1:0] L_DBL  = 7'd12;
	localparam logic [PC_W-1:0] L_MUL  = 7'd17;
	localparam logic [PC_W-1:0] L_LP1  = 7'd22;
	localparam logic [PC_W-1:0] L_X1   = 7'd29;
	localparam logic [PC_W-1:0] L_LP2  = 7'd37;
	localparam logic [PC_W-1:0] L_SKIP = 7'd43;
	localparam logic [PC_W-1:0] L_FIN  = 7'd49;
	localparam logic [PC_W-1:0] L_OUT  = 7'd52;
	localparam logic [PC_W-1:0] L_DBLR = 7'd56;
	localparam logic [PC_W-1:0] L_ADDR = 7'd87;

	function automatic instr_t mk(uop_t k, logic [RF_AW-1:0] d, logic [RF_AW-1:0] a,
			logic [RF_AW-1:0] b, cond_t c, src_t s, logic [PC_W-1:0] t);
		instr_t i;
		i.kind = k; i.dst = d; i.sa = a; i.sb = b; i.cond = c; i.src = s; i.tgt = t;
		return i;
	endfunction

	function automatic instr_t alu(uop_t k, logic [RF_AW-1:0] d, logic [RF_AW-1:0] a,
			logic [RF_AW-1:0] b);
		return mk(k, d, a, b, C_EQ, SRC_FX, '0);
	endfunction

	function automatic instr_t ctl(uop_t k, cond_t c, logic [PC_W-1:0] t);
		return mk(k, '0, '0, '0, c, SRC_FX, t);
	endfunction

	function automatic instr_t ldi(logic [RF_AW-1:0] d, src_t s);
		return mk(U_LDI, d, '0, '0, C_EQ, s, '0);
	endfunction

	// microprogram
	function automatic instr_t rom(logic [PC_W-1:0] pc);
		instr_t i;
		i = ctl(U_ERR, C_EQ, '0);
		case (pc)
			7'd0:   i = ctl(U_BR, C_OP_ADD, L_ADD);
			7'd1:   i = ctl(U_BR, C_OP_DBL, L_DBL);
			7'd2:   i = ctl(U_BR, C_OP_MUL, L_MUL);
			7'd3:   i = ctl(U_ERR, C_EQ, '0);
			// add two points
			7'd4:   i = ldi(R_A0, SRC_FX);
			7'd5:   i = ldi(R_A1, SRC_FY);
			7'd6:   i = ldi(R_A2, SRC_FZ);
			7'd7:   i = ldi(R_D0, SRC_SX);
			7'd8:   i = ldi(R_D1, SRC_SY);
			7'd9:   i = ldi(R_D2, SRC_SZ);
			7'd10:  i = ctl(U_CALL, C_EQ, L_ADDR);
			7'd11:  i = ctl(U_JMP, C_EQ, L_OUT);
			// double one point
			7'd12:  i = ldi(R_D0, SRC_FX);
			7'd13:  i = ldi(R_D1, SRC_FY);
			7'd14:  i = ldi(R_D2, SRC_FZ);
			7'd15:  i = ctl(U_CALL, C_EQ, L_DBLR);
			7'd16:  i = ctl(U_JMP, C_EQ, L_OUT);
			// scalar multiply
			7'd17:  i = ctl(U_BR, C_SC_ZERO, L_ERR);
			7'd18:  i = ldi(R_D0, SRC_FX);
			7'd19:  i = ldi(R_D1, SRC_FY);
			7'd20:  i = ldi(R_D2, SRC_FZ);
			7'd21:  i = ctl(U_LDREM, C_EQ, '0);
			7'd22:  i = ctl(U_BR, C_REM_ODD, L_X1);
			7'd23:  i = ctl(U_CALL, C_EQ, L_DBLR);
			7'd24:  i = alu(U_MOV, R_D0, R_O0, '0);
			7'd25:  i = alu(U_MOV, R_D1, R_O1, '0);
			7'd26:  i = alu(U_MOV, R_D2, R_O2, '0);
			7'd27:  i = ctl(U_SHR, C_EQ, '0);
			7'd28:  i = ctl(U_JMP, C_EQ, L_LP1);
			7'd29:  i = alu(U_MOV, R_A0, R_D0, '0);
			7'd30:  i = alu(U_MOV, R_A1, R_D1, '0);
			7'd31:  i = alu(U_MOV, R_A2, R_D2, '0);
			7'd32:  i = ctl(U_CALL, C_EQ, L_DBLR);
			7'd33:  i = alu(U_MOV, R_D0, R_O0, '0);
			7'd34:  i = alu(U_MOV, R_D1, R_O1, '0);
			7'd35:  i = alu(U_MOV, R_D2, R_O2, '0);
			7'd36:  i = ctl(U_SHR, C_EQ, '0);
			7'd37:  i = ctl(U_BR, C_REM_ZERO, L_FIN);
			7'd38:  i = ctl(U_BR, C_REM_EVEN, L_SKIP);
			7'd39:  i = ctl(U_CALL, C_EQ, L_ADDR);
			7'd40:  i = alu(U_MOV, R_A0, R_O0, '0);
			7'd41:  i = alu(U_MOV, R_A1, R_O1, '0);
			7'd42:  i = alu(U_MOV, R_A2, R_O2, '0);
			7'd43:  i = ctl(U_CALL, C_EQ, L_DBLR);
			7'd44:  i = alu(U_MOV, R_D0, R_O0, '0);
			7'd45:  i = alu(U_MOV, R_D1, R_O1, '0);
			7'd46:  i = alu(U_MOV, R_D2, R_O2, '0);
			7'd47:  i = ctl(U_SHR, C_EQ, '0);
			7'd48:  i = ctl(U_JMP, C_EQ, L_LP2);
			7'd49:  i = alu(U_MOD, R_O0, R_A0, '0);
			7'd50:  i = alu(U_MOD, R_O1, R_A1, '0);
			7'd51:  i = alu(U_MOD, R_O2, R_A2, '0);
			// present result
			7'd52:  i = alu(U_OUT, 5'd0, R_O0, '0);
			7'd53:  i = alu(U_OUT, 5'd1, R_O1, '0);
			7'd54:  i = alu(U_OUT, 5'd2, R_O2, '0);
			7'd55:  i = ctl(U_DONE, C_EQ, '0);
			// double the running double into the result slots
			7'd56:  i = alu(U_MOD, T0, R_D0, '0);
			7'd57:  i = alu(U_MOD, T1, R_D1, '0);
			7'd58:  i = alu(U_MOD, T2, R_D2, '0);
			7'd59:  i = ldi(T3, SRC_CA);
			7'd60:  i = alu(U_MOD, T3, T3, '0);
			7'd61:  i = ldi(T4, SRC_THREE);
			7'd62:  i = alu(U_MOD, T4, T4, '0);
			7'd63:  i = alu(U_MUL, T5, T0, T0);
			7'd64:  i = alu(U_MUL, T6, T2, T2);
			7'd65:  i = alu(U_MUL, T7, T3, T6);
			7'd66:  i = alu(U_MUL, T8, T5, T4);
			7'd67:  i = alu(U_ADD, T7, T7, T8);
			7'd68:  i = alu(U_MUL, T8, T1, T2);
			7'd69:  i = alu(U_ADD, T8, T8, T8);
			7'd70:  i = alu(U_MUL, T9, T8, T8);
			7'd71:  i = alu(U_MUL, R_O2, T8, T9);
			7'd72:  i = alu(U_MUL, T10, T1, T8);
			7'd73:  i = alu(U_MUL, T11, T10, T10);
			7'd74:  i = alu(U_ADD, T12, T10, T0);
			7'd75:  i = alu(U_MUL, T12, T12, T12);
			7'd76:  i = alu(U_SUB, T12, T12, T5);
			7'd77:  i = alu(U_SUB, T12, T12, T11);
			7'd78:  i = alu(U_MUL, T13, T7, T7);
			7'd79:  i = alu(U_ADD, T14, T12, T12);
			7'd80:  i = alu(U_SUB, T13, T13, T14);
			7'd81:  i = alu(U_MUL, R_O0, T13, T8);
			7'd82:  i = alu(U_SUB, T14, T12, T13);
			7'd83:  i = alu(U_MUL, T14, T14, T7);
			7'd84:  i = alu(U_ADD, T15, T11, T11);
			7'd85:  i = alu(U_SUB, R_O1, T14, T15);
			7'd86:  i = ctl(U_RET, C_EQ, '0);
			// add running sum and running double into the result slots; equal points are doubled instead
			7'd87:  i = ctl(U_EQCLR, C_EQ, '0);
			7'd88:  i = alu(U_EQ, '0, R_A0, R_D0);
			7'd89:  i = alu(U_EQ, '0, R_A1, R_D1);
			7'd90:  i = alu(U_EQ, '0, R_A2, R_D2);
			7'd91:  i = ctl(U_BR, C_EQ, L_DBLR);
			7'd92:  i = alu(U_MOD, T0, R_A0, '0);
			7'd93:  i = alu(U_MOD, T1, R_A1, '0);
			7'd94:  i = alu(U_MOD, T2, R_A2, '0);
			7'd95:  i = alu(U_MOD, T3, R_D0, '0);
			7'd96:  i = alu(U_MOD, T4, R_D1, '0);
			7'd97:  i = alu(U_MOD, T5, R_D2, '0);
			7'd98:  i = alu(U_MUL, T6, T0, T5);
			7'd99:  i = alu(U_MUL, T7, T1, T5);
			7'd100: i = alu(U_MUL, T8, T2, T5);
			7'd101: i = alu(U_MUL, T9, T2, T4);
			7'd102: i = alu(U_SUB, T9, T9, T7);
			7'd103: i = alu(U_MUL, T10, T9, T9);
			7'd104: i = alu(U_MUL, T11, T2, T3);
			7'd105: i = alu(U_SUB, T11, T11, T6);
			7'd106: i = alu(U_MUL, T12, T11, T11);
			7'd107: i = alu(U_MUL, T13, T12, T11);
			7'd108: i = alu(U_MUL, T14, T12, T6);
			7'd109: i = alu(U_MUL, T15, T10, T8);
			7'd110: i = alu(U_SUB, T15, T15, T13);
			7'd111: i = alu(U_ADD, T16, T14, T14);
			7'd112: i = alu(U_SUB, T15, T15, T16);
			7'd113: i = alu(U_MUL, R_O0, T15, T11);
			7'd114: i = alu(U_SUB, T16, T14, T15);
			7'd115: i = alu(U_MUL, T16, T16, T9);
			7'd116: i = alu(U_MUL, T17, T13, T7);
			7'd117: i = alu(U_SUB, R_O1, T16, T17);
			7'd118: i = alu(U_MUL, R_O2, T13, T8);
			7'd119: i = ctl(U_RET, C_EQ, '0);
			default: i = ctl(U_ERR, C_EQ, '0);
		endcase
		return i;
	endfunction

endpackage

FILE: src/eppa_ram.sv
// Generic register file RAM: one write port, two registered read ports.
// No dependencies.
module eppa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: src/eppa_alu.sv
// Shared modular arithmetic unit: add, subtract, bit-serial multiply and reduce.
// Depends on eppa_pkg for the request struct.
module eppa_alu import eppa_pkg::*; #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  fu_req_t      req,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] result
);

	localparam int CW = $clog2(W);

	fu_op_t          op_q;
	logic [W-1:0]    a_q, b_q, acc_q;
	logic [CW-1:0]   cnt_q;
	logic            half_q, busy_q, done_q;
	logic            last;
	logic [W:0]      rem2;

	function automatic logic [W-1:0] addm(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] md);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, md}) begin
			s = s - {1'b0, md};
		end
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] subm(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] md);
		return (x >= y) ? x - y : x + (md - y);
	endfunction

	assign last   = (cnt_q == '0);
	assign done   = done_q;
	assign result = acc_q;

	// one restoring division step for the reduction
	always_comb begin
		rem2 = {acc_q, a_q[W-1]};
		if (rem2 >= {1'b0, m}) begin
			rem2 = rem2 - {1'b0, m};
		end
	end

	// latch operands on start; add and subtract then finish directly, multiply and reduce iterate until the count runs out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= FU_ADD;
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			half_q <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			op_q   <= req.op;
			a_q    <= a;
			b_q    <= b;
			acc_q  <= '0;
			cnt_q  <= CW'(W - 1);
			half_q <= 1'b0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			unique case (op_q)
				FU_ADD: begin
					acc_q  <= addm(a_q, b_q, m);
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				FU_SUB: begin
					acc_q  <= subm(a_q, b_q, m);
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				FU_MUL: begin
					if (!half_q && b_q[W-1]) begin
						acc_q  <= addm(acc_q, acc_q, m);
						half_q <= 1'b1;
					end else begin
						acc_q  <= half_q ? addm(acc_q, a_q, m) : addm(acc_q, acc_q, m);
						half_q <= 1'b0;
						b_q    <= b_q << 1;
						cnt_q  <= cnt_q - 1'b1;
						if (last) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
				FU_MOD: begin
					acc_q <= rem2[W-1:0];
					a_q   <= a_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (last) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
				default: begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			endcase
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

FILE: src/ec_projective_point_arith.sv
// Channel   Direction  Handshake             Carries
// in        receive    in_valid / in_stall   opcode, two projective points, scalar
// out       send       out_valid / out_stall out_x, out_y, out_z, error
// cfg       receive    cfg_valid / cfg_ready cfg_index, cfg_data
//
// A microcoded sequencer runs every field operation on the shared unit eppa_alu.
// A multiply iterates over the bits of its second operand and a
// reduction over the bits of its first; an add or subtract does
// not iterate. A scalar multiply runs one point double per scalar
// bit up to the top set bit and one point add per set bit above the lowest.
// Reset clears the sequencer and config registers (curve A 0, modulus 2).
// in_stall stays high from accept until the result transfer completes.
// Depends on eppa_pkg, eppa_alu and eppa_ram.
module ec_projective_point_arith import eppa_pkg::*; #(
	parameter int WIDTH       = 64,
	parameter int SCALAR_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [63:0]          first_x,
	input  logic [63:0]          first_y,
	input  logic [63:0]          first_z,
	input  logic [63:0]          second_x,
	input  logic [63:0]          second_y,
	input  logic [63:0]          second_z,
	input  logic [31:0]          scalar,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [63:0]          out_x,
	output logic [63:0]          out_y,
	output logic [63:0]          out_z,
	output logic                 error,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	state_t                 state_q, state_d;
	logic [PC_W-1:0]        pc_q, pc_d, ret_q;
	instr_t                 ins;
	logic [1:0]             op_q;
	logic [WIDTH-1:0]       fx_q, fy_q, fz_q, sx_q, sy_q, sz_q;
	logic [SCALAR_BITS-1:0] sc_q, rem_q;
	logic [WIDTH-1:0]       ca_q, mod_q, m_eff;
	logic                   eq_q;
	logic [WIDTH-1:0]       ox_q, oy_q, oz_q;
	logic                   err_q;
	logic                   cond_ok;
	logic [WIDTH-1:0]       imm;
	logic                   we;
	logic [WIDTH-1:0]       wdata;
	logic [WIDTH-1:0]       rdata_a, rdata_b;
	fu_req_t                fu_req;
	logic                   fu_done;
	logic [WIDTH-1:0]       fu_res;

	assign ins       = rom(pc_q);
	assign m_eff     = (mod_q == '0) ? WIDTH'(1) : mod_q;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign cfg_ready = 1'b1;
	assign out_x     = 64'(ox_q);
	assign out_y     = 64'(oy_q);
	assign out_z     = 64'(oz_q);
	assign error     = err_q;

	// branch condition
	always_comb begin
		case (ins.cond)
			C_OP_ADD:   cond_ok = (op_q == OP_ADD);
			C_OP_DBL:   cond_ok = (op_q == OP_DBL);
			C_OP_MUL:   cond_ok = (op_q == OP_MUL);
			C_SC_ZERO:  cond_ok = (sc_q == '0);
			C_REM_ODD:  cond_ok = rem_q[0];
			C_REM_EVEN: cond_ok = !rem_q[0];
			C_REM_ZERO: cond_ok = (rem_q == '0);
			C_EQ:       cond_ok = eq_q;
			default:    cond_ok = 1'b0;
		endcase
	end

	// immediate load source
	always_comb begin
		case (ins.src)
			SRC_FX:    imm = fx_q;
			SRC_FY:    imm = fy_q;
			SRC_FZ:    imm = fz_q;
			SRC_SX:    imm = sx_q;
			SRC_SY:    imm = sy_q;
			SRC_SZ:    imm = sz_q;
			SRC_CA:    imm = ca_q;
			SRC_THREE: imm = WIDTH'(3);
			default:   imm = '0;
		endcase
	end

	eppa_ram #(.WIDTH(WIDTH), .DEPTH(RF_DEPTH)) u_rf (
		.clk     (clk),
		.we      (we),
		.waddr   (ins.dst),
		.wdata   (wdata),
		.raddr_a (ins.sa),
		.raddr_b (ins.sb),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	eppa_alu #(.W(WIDTH)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fu_req),
		.a      (rdata_a),
		.b      (rdata_b),
		.m      (m_eff),
		.done   (fu_done),
		.result (fu_res)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	// next state, program counter, write port and unit start
	always_comb begin
		state_d      = state_q;
		pc_d         = pc_q;
		we           = 1'b0;
		wdata        = rdata_a;
		fu_req.start = 1'b0;
		fu_req.op    = FU_ADD;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_FETCH;
					pc_d    = '0;
				end
			end
			ST_FETCH: begin
				pc_d = pc_q + 1'b1;
				case (ins.kind)
					U_BR:   pc_d = cond_ok ? ins.tgt : pc_q + 1'b1;
					U_JMP:  pc_d = ins.tgt;
					U_CALL: pc_d = ins.tgt;
					U_RET:  pc_d = ret_q;
					U_LDI: begin
						we    = 1'b1;
						wdata = imm;
					end
					U_ERR, U_DONE: begin
						pc_d    = pc_q;
						state_d = ST_OUT;
					end
					U_ADD, U_SUB, U_MUL, U_MOD, U_MOV, U_EQ, U_OUT: begin
						pc_d    = pc_q;
						state_d = ST_EXEC;
					end
					default: ;
				endcase
			end
			ST_EXEC: begin
				case (ins.kind)
					U_ADD, U_SUB, U_MUL, U_MOD: begin
						fu_req.start = 1'b1;
						state_d      = ST_WAIT;
						case (ins.kind)
							U_SUB:   fu_req.op = FU_SUB;
							U_MUL:   fu_req.op = FU_MUL;
							U_MOD:   fu_req.op = FU_MOD;
							default: fu_req.op = FU_ADD;
						endcase
					end
					default: begin
						we      = (ins.kind == U_MOV);
						pc_d    = pc_q + 1'b1;
						state_d = ST_FETCH;
					end
				endcase
			end
			ST_WAIT: begin
				if (fu_done) begin
					we      = 1'b1;
					wdata   = fu_res;
					pc_d    = pc_q + 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ca_q  <= '0;
			mod_q <= WIDTH'(2);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CURVE_A: ca_q  <= cfg_data[WIDTH-1:0];
				REG_MODULUS: mod_q <= cfg_data[WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// capture the item, track scalar bits, equality, return address and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= '0;
			fx_q  <= '0;
			fy_q  <= '0;
			fz_q  <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sz_q  <= '0;
			sc_q  <= '0;
			rem_q <= '0;
			eq_q  <= 1'b0;
			ret_q <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
			oz_q  <= '0;
			err_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && in_valid) begin
				op_q <= opcode;
				fx_q <= first_x[WIDTH-1:0];
				fy_q <= first_y[WIDTH-1:0];
				fz_q <= first_z[WIDTH-1:0];
				sx_q <= second_x[WIDTH-1:0];
				sy_q <= second_y[WIDTH-1:0];
				sz_q <= second_z[WIDTH-1:0];
				sc_q <= scalar[SCALAR_BITS-1:0];
			end
			if (state_q == ST_FETCH) begin
				case (ins.kind)
					U_SHR:   rem_q <= rem_q >> 1;
					U_LDREM: rem_q <= sc_q;
					U_EQCLR: eq_q  <= 1'b1;
					U_CALL:  ret_q <= pc_q + 1'b1;
					U_ERR: begin
						ox_q  <= '0;
						oy_q  <= '0;
						oz_q  <= '0;
						err_q <= 1'b1;
					end
					U_DONE:  err_q <= 1'b0;
					default: ;
				endcase
			end
			if (state_q == ST_EXEC) begin
				case (ins.kind)
					U_EQ: eq_q <= eq_q && (rdata_a == rdata_b);
					U_OUT: begin
						case (ins.dst[1:0])
							2'd0:    ox_q <= rdata_a;
							2'd1:    oy_q <= rdata_a;
							default: oz_q <= rdata_a;
						endcase
					end
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: dv/ec_projective_point_arith_test.sv
// Self-checking testbench for ec_projective_point_arith: point add, double and
// scalar multiply checked against an in-bench predictor. Depends on eppa_pkg and the DUT.
`timescale 1ns / 1ps
module ec_projective_point_arith_test;
	import eppa_pkg::*;

	localparam logic [1:0] OP_BAD = 2'd3;
	localparam int unsigned STALL_LIMIT = 2000000;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] PRIME64 = 64'hFFFF_FFFF_FFFF_FFC5;

	typedef struct packed {
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] z;
	} point_t;

	typedef struct packed {
		point_t p;
		logic   err;
	} point_res_t;

	typedef struct packed {
		logic        wr;
		logic [63:0] ca;
		logic [63:0] md;
		logic [1:0]  op;
		point_t      p1;
		point_t      p2;
		logic [31:0] sc;
		logic        known;
		point_res_t  ex;
	} dir_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] opcode = '0;
	logic [63:0] first_x = '0, first_y = '0, first_z = '0;
	logic [63:0] second_x = '0, second_y = '0, second_z = '0;
	logic [31:0] scalar = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [63:0] out_x, out_y, out_z;
	logic error;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	ec_projective_point_arith dut (.*);

	always #5 clk = ~clk;

	// predictor copy of the configuration
	logic [63:0] coeff_a = '0;
	logic [63:0] mod_reg = 64'd2;

	point_res_t expected_pts[$];
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	int unsigned burst_left = 0;
	dir_row_t dir_tab[$];
	dir_row_t row_q;
	point_t pa, pb;
	logic [1:0] rop;
	logic [31:0] rsc;
	int unsigned pick;

	function automatic logic [63:0] eff_mod();
		return (mod_reg == 0) ? 64'd1 : mod_reg;
	endfunction

	function automatic logic [63:0] fadd(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, m}) ? 64'(s - {1'b0, m}) : s[63:0];
	endfunction

	function automatic logic [63:0] fsub(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		return (a >= b) ? a - b : a + (m - b);
	endfunction

	function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p % {64'd0, m});
	endfunction

	function automatic point_t point_double(point_t p);
		logic [63:0] m, x, y, z, ca, xx, zz, w, yz, s, t, rr, tx, b, lam;
		point_t o;
		m = eff_mod();
		x = p.x % m; y = p.y % m; z = p.z % m;
		ca = coeff_a % m;
		xx = fmul(x, x, m);
		zz = fmul(z, z, m);
		w = fadd(fmul(ca, zz, m), fmul(xx, 64'd3 % m, m), m);
		yz = fmul(y, z, m);
		s = fadd(yz, yz, m);
		o.z = fmul(s, fmul(s, s, m), m);
		t = fmul(y, s, m);
		rr = fmul(t, t, m);
		tx = fadd(t, x, m);
		b = fsub(fsub(fmul(tx, tx, m), xx, m), rr, m);
		lam = fsub(fmul(w, w, m), fadd(b, b, m), m);
		o.x = fmul(lam, s, m);
		o.y = fsub(fmul(fsub(b, lam, m), w, m), fadd(rr, rr, m), m);
		return o;
	endfunction

	function automatic point_t point_add(point_t p, point_t q);
		logic [63:0] m, x1, y1, z1, x2, y2, z2, x1z2, y1z2, z1z2, u, uu, v, vv, vvv, r, a;
		point_t o;
		// identical raw operands fall back to doubling
		if (p == q)
			return point_double(p);
		m = eff_mod();
		x1 = p.x % m; y1 = p.y % m; z1 = p.z % m;
		x2 = q.x % m; y2 = q.y % m; z2 = q.z % m;
		x1z2 = fmul(x1, z2, m);
		y1z2 = fmul(y1, z2, m);
		z1z2 = fmul(z1, z2, m);
		u = fsub(fmul(z1, y2, m), y1z2, m);
		uu = fmul(u, u, m);
		v = fsub(fmul(z1, x2, m), x1z2, m);
		vv = fmul(v, v, m);
		vvv = fmul(vv, v, m);
		r = fmul(vv, x1z2, m);
		a = fsub(fsub(fmul(uu, z1z2, m), vvv, m), fadd(r, r, m), m);
		o.x = fmul(a, v, m);
		o.y = fsub(fmul(fsub(r, a, m), u, m), fmul(vvv, y1z2, m), m);
		o.z = fmul(vvv, z1z2, m);
		return o;
	endfunction

	function automatic point_res_t predict_point(logic [1:0] op, point_t p1, point_t p2,
			logic [31:0] sc);
		point_res_t res;
		point_t acc, dbl;
		logic [31:0] rem;
		logic [63:0] m;
		res = '0;
		m = eff_mod();
		if (op == OP_ADD) begin
			res.p = point_add(p1, p2);
		end else if (op == OP_DBL) begin
			res.p = point_double(p1);
		end else if (op == OP_MUL && sc != 0) begin
			// right-to-left double and add; the running sum starts raw
			dbl = p1;
			rem = sc;
			while (rem[0] == 1'b0) begin
				dbl = point_double(dbl);
				rem = rem >> 1;
			end
			acc = dbl;
			dbl = point_double(dbl);
			rem = rem >> 1;
			while (rem != 0) begin
				if (rem[0])
					acc = point_add(acc, dbl);
				dbl = point_double(dbl);
				rem = rem >> 1;
			end
			res.p.x = acc.x % m;
			res.p.y = acc.y % m;
			res.p.z = acc.z % m;
		end else begin
			res.err = 1'b1;
		end
		return res;
	endfunction

	function automatic logic [63:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return ALL_ONES;
			1: return 64'($urandom_range(0, 200));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// watchdog: any transfer restarts the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver stall pattern: stretches of no stall, light stall and heavy stall
	int unsigned stall_mode = 0;
	int unsigned stall_span = 0;
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_span <= $urandom_range(20, 300);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// compare each result transfer with the oldest expected point
	always @(posedge clk) begin
		point_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h %h %h err %b", out_x, out_y, out_z, error);
			end else begin
				e = expected_pts.pop_front();
				if (out_x !== e.p.x || out_y !== e.p.y || out_z !== e.p.z || error !== e.err) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h %h %h err %b, got %h %h %h err %b",
							e.p.x, e.p.y, e.p.z, e.err, out_x, out_y, out_z, error);
				end
			end
		end
	end

	task automatic drain();
		while (expected_pts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_CURVE_A)
			coeff_a = val;
		else
			mod_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_curve(logic [63:0] ca, logic [63:0] md);
		drain();
		write_reg(REG_CURVE_A, ca);
		write_reg(REG_MODULUS, md);
	endtask

	// send one item; a known expectation overrides the predictor
	task automatic send_point(logic [1:0] op, point_t p1, point_t p2, logic [31:0] sc,
			logic known, point_res_t ex);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 6);
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= op;
		first_x <= p1.x; first_y <= p1.y; first_z <= p1.z;
		second_x <= p2.x; second_y <= p2.y; second_z <= p2.z;
		scalar <= sc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_pts.push_back(known ? ex : predict_point(op, p1, p2, sc));
		@(negedge clk);
	endtask

	initial begin
		// directed table: config write flag, config, item, optional known result
		dir_tab.push_back('{0, 0, 0, OP_ADD, '0, '0, 0, 0, '0});
		dir_tab.push_back('{0, 0, 0, OP_DBL, '{ALL_ONES, ALL_ONES, ALL_ONES}, '0, 0, 0, '0});
		dir_tab.push_back('{0, 0, 0, OP_MUL, '{5, 6, 7}, '0, 0, 1, '{'0, 1'b1}});
		dir_tab.push_back('{0, 0, 0, OP_BAD, '{5, 6, 7}, '{1, 2, 3}, 9, 1, '{'0, 1'b1}});
		dir_tab.push_back('{1, 0, 1, OP_ADD, '{ALL_ONES, 1, 2}, '{3, 4, 5}, 0, 1, '0});
		dir_tab.push_back('{0, 0, 0, OP_MUL, '{7, 8, 9}, '0, 5, 1, '0});
		dir_tab.push_back('{1, ALL_ONES, 0, OP_DBL, '{11, 12, 13}, '0, 0, 1, '0});
		dir_tab.push_back('{1, ALL_ONES, ALL_ONES, OP_ADD,
			'{ALL_ONES, ALL_ONES, ALL_ONES}, '0, 0, 0, '0});
		dir_tab.push_back('{0, 0, 0, OP_ADD, '{123, 456, 789}, '{123, 456, 789}, 0, 0, '0});
		dir_tab.push_back('{0, 0, 0, OP_DBL, '{ALL_ONES, 3, ALL_ONES}, '0, 0, 0, '0});
		dir_tab.push_back('{0, 0, 0, OP_MUL, '{64'h1234_5678_9ABC_DEF0, 64'hFEDC_BA98_7654_3210,
			1}, '0, 32'hFFFF_FFFF, 0, '0});
		dir_tab.push_back('{0, 0, 0, OP_MUL, '{3, 5, 1}, '0, 32'h8000_0000, 0, '0});
		dir_tab.push_back('{0, 0, 0, OP_MUL, '{ALL_ONES, 2, 1}, '0, 1, 0, '0});
		dir_tab.push_back('{1, 2, 97, OP_ADD, '{1, 2, 3}, '{98, 99, 100}, 0, 0, '0});
		dir_tab.push_back('{0, 0, 0, OP_ADD, '{40, 41, 1}, '{40, 41, 1}, 0, 0, '0});
		dir_tab.push_back('{0, 0, 0, OP_MUL, '{3, 10, 1}, '0, 32'h2A, 0, '0});
		dir_tab.push_back('{0, 0, 0, OP_MUL, '{3, 10, 1}, '0, 3, 0, '0});
		dir_tab.push_back('{1, 0, PRIME64, OP_ADD, '{PRIME64, 1, 1}, '{2, ALL_ONES, 1},
			0, 0, '0});
		dir_tab.push_back('{0, 0, 0, OP_MUL, '{9, 17, 1}, '0, 6, 0, '0});
		dir_tab.push_back('{0, 0, 0, OP_BAD, '0, '0, 0, 1, '{'0, 1'b1}});

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (dir_tab[i]) begin
			row_q = dir_tab[i];
			if (row_q.wr) begin
				// drop valid so the last item is not offered again while draining
				in_valid <= 1'b0;
				set_curve(row_q.ca, row_q.md);
			end
			send_point(row_q.op, row_q.p1, row_q.p2, row_q.sc, row_q.known, row_q.ex);
		end
		in_valid <= 1'b0;

		// random phases, each under a fresh curve; the drain before each is a full pause
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_curve({$urandom, $urandom}, PRIME64);
				1: set_curve({$urandom, $urandom}, {1'b1, 31'($urandom), $urandom});
				2: set_curve(64'($urandom_range(0, 5)), 64'($urandom_range(2, 1000)));
				3: set_curve(ALL_ONES, ALL_ONES);
				default: set_curve({$urandom, $urandom}, 64'($urandom_range(0, 3)));
			endcase
			for (int n = 0; n < 20; n++) begin
				pick = $urandom_range(0, 99);
				rop = (pick < 40) ? OP_ADD : (pick < 70) ? OP_DBL : (pick < 92) ? OP_MUL : OP_BAD;
				pa = '{rand_coord(), rand_coord(), rand_coord()};
				pb = ($urandom_range(0, 9) == 0) ? pa : '{rand_coord(), rand_coord(), rand_coord()};
				rsc = ($urandom_range(0, 19) == 0) ? 32'd0 : 32'($urandom_range(1, 15));
				send_point(rop, pa, pb, rsc, 1'b0, '0);
			end
			in_valid <= 1'b0;
		end

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
src/eppa_pkg.sv
src/eppa_ram.sv
src/eppa_alu.sv
src/ec_projective_point_arith.sv
dv/ec_projective_point_arith_test.sv
